// ===== src/canonical_huffman_table_builder_macros.svh =====
// assertion helpers used by the checker file
`ifndef CANONICAL_HUFFMAN_TABLE_BUILDER_MACROS_SVH
`define CANONICAL_HUFFMAN_TABLE_BUILDER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CHTB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define CHTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/chtb_pkg.sv =====
package chtb_pkg;

  // number of per-length count slots in a table description
  localparam int CountSlots = 16;
  // saturation point of the code counter
  localparam logic [16:0] CodeSat = 17'h10000;

  // transaction kinds on the input channel
  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_ASSIGN  = 2'd1,
    KIND_LOOKUP  = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_COUNT_REJECT  = 3'd1,
    ST_SURPLUS       = 3'd2,
    ST_OVERFLOW      = 3'd3,
    ST_NOT_ASSIGNED  = 3'd4
  } status_t;

  // request from the sequencer to the code store
  typedef struct packed {
    logic        we;
    logic        re;
    logic        clr;
    logic [7:0]  addr;
    logic [4:0]  wlen;
    logic [15:0] wcode;
  } mem_req_t;

  // registered read data of the code store
  typedef struct packed {
    logic        hit;
    logic [4:0]  len;
    logic [15:0] code;
  } mem_rsp_t;

  // one result, packed with symbol in the low bits
  typedef struct packed {
    status_t     status;
    logic [4:0]  code_length;
    logic [15:0] code;
    logic [7:0]  symbol;
  } result_t;

endpackage

// ===== src/chtb_store.sv =====
module chtb_store
  import chtb_pkg::*;
#(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  localparam int SymW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic [20:0]             store_r [SYMBOL_COUNT];
  logic [20:0]             rd_word_r;
  logic                    rd_hit_r;
  logic [SYMBOL_COUNT-1:0] valid_r;
  logic [SymW-1:0]         idx;

  assign idx = req.addr[SymW-1:0];

  // code and length per symbol, registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      store_r[idx] <= {req.wlen, req.wcode};
    end
    if (req.re) begin
      rd_word_r <= store_r[idx];
    end
  end

  // per-symbol valid marks, cleared at reset and on restart
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_hit_r <= valid_r[idx];
    end
  end

  assign rsp.hit  = rd_hit_r;
  assign rsp.len  = rd_word_r[20:16];
  assign rsp.code = rd_word_r[15:0];

endmodule

// ===== src/chtb_ctrl.sv =====
module chtb_ctrl
  import chtb_pkg::*;
#(
  parameter int MAX_CODE_LENGTH = 16,
  parameter int SYMBOL_COUNT    = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kind_t    in_kind,
  input  logic [7:0] in_value,
  output mem_req_t mem_req,
  input  mem_rsp_t mem_rsp,
  output logic     res_valid,
  output result_t  res,
  input  logic     res_take
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SKIP,
    S_LOOK,
    S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  value_r, value_nxt;
  logic [7:0]  counts_r [CountSlots];
  logic [4:0]  loaded_r, loaded_nxt;
  logic [4:0]  cur_len_r, cur_len_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [16:0] next_code_r, next_code_nxt;
  result_t     res_r, res_nxt;
  logic        cnt_we;

  logic        in_range;
  logic        overflow;
  logic [17:0] shifted;
  logic [17:0] bumped;
  logic [17:0] len_limit;

  // saturate a grown code counter value
  function automatic logic [16:0] sat_code(input logic [17:0] v);
    logic [16:0] r;
    r = (v > {1'b0, CodeSat}) ? CodeSat : v[16:0];
    return r;
  endfunction

  assign shifted   = {next_code_r, 1'b0};
  assign bumped    = {1'b0, next_code_r} + 18'd1;
  assign len_limit = 18'd1 << cur_len_r;
  assign overflow  = {1'b0, next_code_r} >= len_limit;
  assign in_range  = {1'b0, value_r} < 9'(SYMBOL_COUNT);

  // sequencer: one length step per cycle while skipping
  always_comb begin
    state_nxt     = state_r;
    value_nxt     = value_r;
    loaded_nxt    = loaded_r;
    cur_len_nxt   = cur_len_r;
    left_nxt      = left_r;
    next_code_nxt = next_code_r;
    res_nxt       = res_r;
    cnt_we        = 1'b0;
    mem_req       = '0;
    mem_req.addr  = value_r;
    mem_req.wlen  = cur_len_r;
    mem_req.wcode = next_code_r[15:0];

    case (state_r)
      S_IDLE: begin
        mem_req.addr = in_value;
        if (in_valid) begin
          value_nxt          = in_value;
          res_nxt.symbol     = in_value;
          res_nxt.code       = '0;
          res_nxt.code_length = '0;
          res_nxt.status     = ST_OK;
          case (in_kind)
            KIND_LOAD: begin
              if (loaded_r >= 5'(MAX_CODE_LENGTH) || cur_len_r != 5'd0) begin
                res_nxt.status = ST_COUNT_REJECT;
              end else begin
                cnt_we     = 1'b1;
                loaded_nxt = loaded_r + 5'd1;
              end
              state_nxt = S_DONE;
            end
            KIND_ASSIGN: begin
              state_nxt = S_SKIP;
            end
            KIND_LOOKUP: begin
              mem_req.re = 1'b1;
              state_nxt  = S_LOOK;
            end
            KIND_RESTART: begin
              loaded_nxt    = '0;
              cur_len_nxt   = '0;
              left_nxt      = '0;
              next_code_nxt = '0;
              mem_req.clr   = 1'b1;
              state_nxt     = S_DONE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SKIP: begin
        if (left_r == 8'd0 && cur_len_r < 5'(MAX_CODE_LENGTH)) begin
          // advance to the next length, empty ones pass one per cycle
          if (cur_len_r != 5'd0) begin
            next_code_nxt = sat_code(shifted);
          end
          cur_len_nxt = cur_len_r + 5'd1;
          left_nxt    = (cur_len_r < loaded_r) ? counts_r[cur_len_r[3:0]] : 8'd0;
        end else begin
          if (left_r == 8'd0) begin
            res_nxt.status = ST_SURPLUS;
          end else begin
            left_nxt      = left_r - 8'd1;
            next_code_nxt = sat_code(bumped);
            if (overflow) begin
              res_nxt.status = ST_OVERFLOW;
            end else if (!in_range) begin
              res_nxt.status = ST_NOT_ASSIGNED;
            end else begin
              mem_req.we          = 1'b1;
              res_nxt.code        = next_code_r[15:0];
              res_nxt.code_length = cur_len_r;
            end
          end
          state_nxt = S_DONE;
        end
      end

      S_LOOK: begin
        if (in_range && mem_rsp.hit) begin
          res_nxt.code        = mem_rsp.code;
          res_nxt.code_length = mem_rsp.len;
        end else begin
          res_nxt.status = ST_NOT_ASSIGNED;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      cur_len_r   <= '0;
      left_r      <= '0;
      next_code_r <= '0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      cur_len_r   <= cur_len_nxt;
      left_r      <= left_nxt;
      next_code_r <= next_code_nxt;
    end
    value_r <= value_nxt;
    res_r   <= res_nxt;
    if (cnt_we) begin
      counts_r[loaded_r[3:0]] <= in_value;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

// ===== src/canonical_huffman_table_builder.sv =====
// Canonical Huffman encoder table builder.
// Input channel: in_tuser carries the transaction kind (load count, assign
// symbol, lookup symbol, restart), in_tdata the count or symbol value.
// Result channel: exactly one result per input transaction, in order.
// A table is built by loading up to MAX_CODE_LENGTH per-length counts and
// then assigning symbols in table order; lookups read code and length back.
// Load and restart go straight to the result; a lookup first reads the
// code store through its registered read port, and an assign advances
// lengths one per cycle before its result.
// Items are worked on one at a time: the block is ready for the next
// accept in the cycle after the result moves to the output register.
// Lookups wait on the code store read port and assigns on the
// length-advance loop of the sequencer.
// The output register holds a finished result while the next transaction
// is accepted; a stalled receiver stops the block once that result and the
// next one are both waiting.
// Reset (and the restart kind) clears all progress and every valid mark;
// lookups of symbols not assigned since then report not assigned.
module canonical_huffman_table_builder
  import chtb_pkg::*;
#(
  parameter int MAX_CODE_LENGTH = 16,
  parameter int SYMBOL_COUNT    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // value
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // symbol, code, code_length, status
);

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;
  logic     res_valid;
  result_t  res;
  logic     res_take;
  logic     out_valid_r;
  result_t  out_data_r;

  chtb_ctrl #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
    .SYMBOL_COUNT   (SYMBOL_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (kind_t'(in_tuser)),
    .in_value (in_tdata),
    .mem_req  (mem_req),
    .mem_rsp  (mem_rsp),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  chtb_store #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mem_req),
    .rsp  (mem_rsp)
  );

  // output register, refilled when empty or being taken
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/chtb_checker.sv =====
`include "canonical_huffman_table_builder_macros.svh"

module chtb_checker
  import chtb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result holds
  `CHTB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // any error result carries no code and no length
  `CHTB_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_tvalid && out_tdata[31:29] != ST_OK, out_tdata[28:8] == 21'h0, "error result with code or length")

  // the code fits in its length
  `CHTB_ASSERT_IMPLY(a_code_fits, clk, rst_n, out_tvalid, (out_tdata[23:8] >> out_tdata[28:24]) == 16'h0 && out_tdata[28:24] <= 5'd16, "code wider than its length")

  // the block is busy in the cycle after an accept
  `CHTB_ASSERT_NEXT(a_busy_after, clk, rst_n, in_tvalid && in_tready, !in_tready, "input accepted on back-to-back cycles")

endmodule

bind canonical_huffman_table_builder chtb_checker u_chtb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ===== tb/sv/canonical_huffman_table_builder_tb.sv =====
`timescale 1ns / 1ps

module canonical_huffman_table_builder_tb;
  import chtb_pkg::*;

  localparam int MaxLen     = 16;
  localparam int StallLimit = 4000;
  localparam int DrainTail  = 24;

  typedef struct {
    kind_t      kind;
    logic [7:0] value;
  } table_op_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  // stimulus and scoreboard state
  table_op_t table_ops_pending[$];
  result_t   code_results_due[$];
  int        ops_queued;
  int        ops_taken;
  int        error_count;
  int        quiet_cycles;
  int        send_idle_pct;
  int        recv_stall_pct;
  logic      in_fire;

  // predicted table state
  logic [7:0]  count_by_len[MaxLen];
  int          counts_seen;
  int          active_len;
  int          codes_left;
  int          code_counter;
  logic [15:0] code_by_sym[256];
  logic [4:0]  len_by_sym[256];
  bit          sym_assigned[256];

  canonical_huffman_table_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic void clear_table_state();
    counts_seen  = 0;
    active_len   = 0;
    codes_left   = 0;
    code_counter = 0;
    foreach (sym_assigned[i]) sym_assigned[i] = 1'b0;
  endfunction

  // expected result of one transaction, updating the predicted table
  function automatic result_t compute_code_result(kind_t kind, logic [7:0] value);
    result_t res;
    int      code;
    res.symbol      = value;
    res.code        = '0;
    res.code_length = '0;
    res.status      = ST_OK;
    case (kind)
      KIND_LOAD: begin
        if (counts_seen >= MaxLen || active_len != 0) begin
          res.status = ST_COUNT_REJECT;
        end else begin
          count_by_len[counts_seen] = value;
          counts_seen++;
        end
      end
      KIND_ASSIGN: begin
        // advance past exhausted and empty lengths
        while (codes_left == 0 && active_len < MaxLen) begin
          if (active_len != 0) begin
            code_counter = code_counter << 1;
            if (code_counter > int'(CodeSat)) code_counter = int'(CodeSat);
          end
          active_len++;
          codes_left = (active_len - 1 < counts_seen) ? int'(count_by_len[active_len - 1]) : 0;
        end
        if (codes_left == 0) begin
          res.status = ST_SURPLUS;
        end else begin
          code = code_counter;
          codes_left--;
          code_counter++;
          if (code_counter > int'(CodeSat)) code_counter = int'(CodeSat);
          if (code >= (1 << active_len)) begin
            res.status = ST_OVERFLOW;
          end else begin
            code_by_sym[value]  = code[15:0];
            len_by_sym[value]   = active_len[4:0];
            sym_assigned[value] = 1'b1;
            res.code            = code[15:0];
            res.code_length     = active_len[4:0];
          end
        end
      end
      KIND_LOOKUP: begin
        if (sym_assigned[value]) begin
          res.code        = code_by_sym[value];
          res.code_length = len_by_sym[value];
        end else begin
          res.status = ST_NOT_ASSIGNED;
        end
      end
      default: clear_table_state();
    endcase
    return res;
  endfunction

  task automatic push_op(input kind_t kind, input logic [7:0] value);
    table_op_t op;
    op.kind  = kind;
    op.value = value;
    table_ops_pending.push_back(op);
    ops_queued++;
  endtask

  // mostly well-formed table builds with random content, some noise
  task automatic queue_random_ops(input int n_ops);
    int         start;
    int         n_loads;
    int         room;
    int         cnt;
    int         total;
    int         n_syms;
    logic [7:0] sym;
    logic [7:0] used_syms[$];
    start = ops_queued;
    while (ops_queued - start < n_ops) begin
      if ($urandom_range(9) == 0) begin
        // noise burst of arbitrary transactions
        repeat ($urandom_range(1, 6)) push_op(kind_t'($urandom_range(3)), 8'($urandom));
      end else begin
        used_syms.delete();
        push_op(KIND_RESTART, 8'($urandom));
        n_loads = ($urandom_range(3) == 0) ? $urandom_range(0, 20) : MaxLen;
        room    = 2;
        total   = 0;
        for (int i = 0; i < n_loads; i++) begin
          // counts past the table size and oversize counts break the tree
          if (i >= MaxLen || $urandom_range(9) == 0) cnt = $urandom_range(255);
          else if ($urandom_range(1) == 0) cnt = 0;
          else cnt = $urandom_range(0, (room < 3) ? room : 3);
          push_op(KIND_LOAD, 8'(cnt));
          if (i < MaxLen) begin
            total += cnt;
            room = (room > cnt) ? (room - cnt) * 2 : 0;
            if (room > 1000) room = 1000;
          end
        end
        n_syms = ((total > 40) ? 40 : total) + $urandom_range(0, 2);
        for (int i = 0; i < n_syms; i++) begin
          if ($urandom_range(4) == 0) begin
            if (used_syms.size() != 0 && $urandom_range(1) == 0)
              push_op(KIND_LOOKUP, used_syms[$urandom_range(used_syms.size() - 1)]);
            else
              push_op(KIND_LOOKUP, 8'($urandom));
          end
          if ($urandom_range(7) == 0) push_op(KIND_LOAD, 8'($urandom));
          sym = 8'($urandom);
          used_syms.push_back(sym);
          push_op(KIND_ASSIGN, sym);
        end
        // read back part of the table
        repeat ($urandom_range(2, 6)) begin
          if (used_syms.size() != 0 && $urandom_range(3) != 0)
            push_op(KIND_LOOKUP, used_syms[$urandom_range(used_syms.size() - 1)]);
          else
            push_op(KIND_LOOKUP, 8'($urandom));
        end
      end
    end
  endtask

  // input driver and receiver backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_fire) begin
        if (table_ops_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tuser  <= table_ops_pending[0].kind;
          in_tdata  <= table_ops_pending[0].value;
          void'(table_ops_pending.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input transactions, check on result transactions
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      in_fire      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        code_results_due.push_back(compute_code_result(kind_t'(in_tuser), in_tdata));
        ops_taken <= ops_taken + 1;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (code_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
          error_count++;
        end else begin
          want = code_results_due.pop_front();
          if (got.symbol !== want.symbol || got.code !== want.code ||
              got.code_length !== want.code_length || got.status !== want.status) begin
            $display("%0t: mismatch sym/code/len/status expected %h/%h/%0d/%0d got %h/%h/%0d/%0d",
                     $time, want.symbol, want.code, want.code_length, want.status,
                     got.symbol, got.code, got.code_length, got.status);
            error_count++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog on a stuck handshake
  initial begin
    while (quiet_cycles < StallLimit) @(negedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = KIND_LOAD;
    out_tready     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    ops_queued     = 0;
    ops_taken      = 0;
    error_count    = 0;
    quiet_cycles   = 0;
    in_fire        = 1'b0;
    clear_table_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: lookup before any table
    push_op(KIND_LOOKUP, 8'hFF);
    // no codes at length 1, two at length 2, oversize count at length 3
    push_op(KIND_LOAD, 8'h00);
    push_op(KIND_LOAD, 8'h02);
    push_op(KIND_LOAD, 8'hFF);
    push_op(KIND_ASSIGN, 8'h00);
    // count after assignment began is rejected
    push_op(KIND_LOAD, 8'h01);
    push_op(KIND_ASSIGN, 8'hFF);
    push_op(KIND_ASSIGN, 8'h11);
    // duplicate symbol overwrites its earlier entry
    push_op(KIND_ASSIGN, 8'h00);
    push_op(KIND_ASSIGN, 8'h03);
    push_op(KIND_ASSIGN, 8'h04);
    // code no longer fits in three bits
    push_op(KIND_ASSIGN, 8'h09);
    push_op(KIND_ASSIGN, 8'h0A);
    push_op(KIND_LOOKUP, 8'h00);
    push_op(KIND_LOOKUP, 8'hFF);
    push_op(KIND_LOOKUP, 8'h09);
    // restart clears every entry, then no counts leaves only surplus
    push_op(KIND_RESTART, 8'hAA);
    push_op(KIND_LOOKUP, 8'h00);
    push_op(KIND_ASSIGN, 8'h55);
    push_op(KIND_RESTART, 8'h00);
    // single code at length 1, then surplus
    push_op(KIND_LOAD, 8'h01);
    push_op(KIND_ASSIGN, 8'h7F);
    push_op(KIND_ASSIGN, 8'h80);
    push_op(KIND_LOOKUP, 8'h7F);

    // random phases with different idling patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
        end
      endcase
      queue_random_ops(425);
      while (ops_taken != ops_queued) @(negedge clk);
    end

    // drain
    while (code_results_due.size() != 0) @(negedge clk);
    repeat (DrainTail) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
